>>> design/mass_energy_balance_checker_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the balance checker
// Shared property forms used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef MASS_ENERGY_BALANCE_CHECKER_CORE_MACROS_SVH
`define MASS_ENERGY_BALANCE_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MEBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define MEBC_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mebc_pkg.sv
// ---------------------------------------------------------------------------
// Balance checker package
// Item codes, transfer structs, sizing constants and saturating arithmetic.
// ---------------------------------------------------------------------------
package mebc_pkg;

  // Node count limit and the cap seen on the 21-bit count field.
  localparam int unsigned MAX_NODES       = 1048576;
  localparam int unsigned FIELD_COUNT_MAX = 2097151;
  localparam logic [20:0] COUNT_CAP =
    21'((MAX_NODES < FIELD_COUNT_MAX) ? MAX_NODES : FIELD_COUNT_MAX);

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port address map.
  localparam int unsigned           CFG_ADDR_W       = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_AIR_ENABLED = '0;

  // Item operation codes.
  localparam logic [1:0] OP_NODE   = 2'd0;
  localparam logic [1:0] OP_SOURCE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // Signed 64-bit saturation limits.
  localparam logic signed [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'h8000_0000_0000_0000;

  // One input item as held in the queue.
  typedef struct packed {
    logic        [1:0]  operation;
    logic        [19:0] node_index;
    logic        [31:0] pore_volume;
    logic        [31:0] bulk_volume;
    logic signed [31:0] fluid_density;
    logic signed [31:0] salt_density;
    logic signed [31:0] enthalpy_density;
    logic signed [31:0] air_density;
    logic signed [31:0] mass_term;
    logic signed [31:0] energy_term;
    logic signed [31:0] salt_term;
    logic signed [31:0] air_term;
  } item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Request to and response from the shared divider.
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  // One end-of-pass result.
  typedef struct packed {
    logic signed [63:0] mass_residual;
    logic signed [63:0] energy_residual;
    logic signed [63:0] salt_residual;
    logic signed [63:0] air_residual;
    logic signed [31:0] mass_relative;
    logic signed [31:0] energy_relative;
    logic signed [63:0] mass_storage;
    logic signed [63:0] energy_storage;
    logic        [19:0] worst_node;
    logic        [20:0] node_count;
    logic               baseline_valid;
  } result_t;

  // Saturating signed add.
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) begin
      return a[63] ? SMIN : SMAX;
    end
    return r;
  endfunction

  // Saturating signed subtract.
  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) begin
      return a[63] ? SMIN : SMAX;
    end
    return r;
  endfunction

  // Magnitude as an unsigned 64-bit value (the most negative value maps to 2^63).
  function automatic logic [63:0] uabs(input logic signed [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // Q16.16 delta widened to Q32.32.
  function automatic logic signed [63:0] widen(input logic signed [31:0] x);
    return {{16{x[31]}}, x, 16'h0000};
  endfunction

endpackage

>>> design/mebc_front.sv
// ---------------------------------------------------------------------------
// Balance checker front end
// Accepts input items, drops unused operation codes and queues the rest.
// ---------------------------------------------------------------------------
module mebc_front import mebc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t item,
  output logic  full,
  output head_t head,
  input  logic  hd_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          known_op;
  logic          wr_en;
  logic          rd_en;

  // Classify the item: only node, source and end-of-pass items do anything.
  assign known_op = (item.operation == OP_NODE) || (item.operation == OP_SOURCE) ||
                    (item.operation == OP_END);

  assign full  = (cnt_r == FULL_CNT);
  assign wr_en = push && !full && known_op;
  assign rd_en = hd_pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

>>> design/mebc_div.sv
// ---------------------------------------------------------------------------
// Balance checker relative-residual divider
// Bit-serial signed Q1.30 quotient of residual over |storage|, saturated.
// ---------------------------------------------------------------------------
module mebc_div import mebc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned   FRAC_BITS = 30;
  localparam int unsigned   CNT_W     = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS - 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_INIT,
    D_STEP,
    D_DONE
  } dstate_t;

  dstate_t          state_r, state_nxt;
  logic [63:0]      n_r, n_nxt;
  logic [63:0]      d_r, d_nxt;
  logic [63:0]      rem_r, rem_nxt;
  logic [30:0]      q_r, q_nxt;
  logic             neg_r, neg_nxt;
  logic             sat_r, sat_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_sub;
  logic             bit_ge;
  logic [31:0]      q_ext;

  // One restoring step on the shifted remainder.
  assign rem_sh  = {rem_r, 1'b0};
  assign bit_ge  = (rem_sh >= {1'b0, d_r});
  assign rem_sub = rem_sh - {1'b0, d_r};

  // Sign and saturation of the finished quotient.
  assign q_ext = {1'b0, q_r};
  always_comb begin
    rsp.done = (state_r == D_DONE);
    if (neg_r) begin
      rsp.quot = sat_r ? 32'sh8000_0000 : $signed(~q_ext + 32'd1);
    end else begin
      rsp.quot = sat_r ? 32'sh7FFF_FFFF : $signed(q_ext);
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    sat_nxt   = sat_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          n_nxt     = uabs(req.num);
          d_nxt     = uabs(req.den);
          neg_nxt   = req.num[63];
          state_nxt = D_INIT;
        end
      end
      // Integer part: two or more saturates, else one quotient bit.
      D_INIT: begin
        cnt_nxt = '0;
        if ({1'b0, n_r} >= {d_r, 1'b0}) begin
          sat_nxt   = 1'b1;
          state_nxt = D_DONE;
        end else begin
          sat_nxt   = 1'b0;
          state_nxt = D_STEP;
          if (n_r >= d_r) begin
            rem_nxt = n_r - d_r;
            q_nxt   = 31'd1;
          end else begin
            rem_nxt = n_r;
            q_nxt   = '0;
          end
        end
      end
      // Fraction bits, one per cycle.
      D_STEP: begin
        rem_nxt = bit_ge ? rem_sub[63:0] : rem_sh[63:0];
        q_nxt   = {q_r[29:0], bit_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = D_DONE;
        end
      end
      D_DONE: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

>>> design/mebc_back.sv
// ---------------------------------------------------------------------------
// Balance checker back end
// Accumulates per-pass sums, builds end-of-pass results and holds the output.
// ---------------------------------------------------------------------------
module mebc_back import mebc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     air_enabled,
  input  head_t    head,
  output logic     hd_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     out_valid,
  output result_t  result,
  input  logic     out_pop
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIFF,
    ST_OUTF,
    ST_EXT,
    ST_REL_M,
    ST_WAIT_M,
    ST_REL_E,
    ST_WAIT_E,
    ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [63:0] storage_r [4];
  logic signed [63:0] storage_nxt [4];
  logic signed [63:0] outflow_r [4];
  logic signed [63:0] outflow_nxt [4];
  logic signed [63:0] prev_r [4];
  logic signed [63:0] prev_nxt [4];
  logic signed [63:0] ext_r [4];
  logic signed [63:0] ext_nxt [4];
  logic signed [63:0] prod_r [8];
  logic signed [63:0] prod_nxt [8];
  logic signed [63:0] res_r [4];
  logic signed [63:0] res_nxt [4];
  logic        [63:0] worst_mag_r, worst_mag_nxt;
  logic        [19:0] worst_node_r, worst_node_nxt;
  logic        [19:0] node_r, node_nxt;
  logic        [20:0] nodes_r, nodes_nxt;
  logic               base_r, base_nxt;
  logic signed [31:0] rm_r, rm_nxt;
  logic signed [31:0] re_r, re_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;
  logic        [63:0] flow_mag;

  // Exact Q32.32 product of a signed Q16.16 value and an unsigned Q16.16 volume.
  function automatic logic signed [63:0] qmul(input logic signed [31:0] s,
                                              input logic        [31:0] u);
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic signed [65:0] p;
    a = {s[31], s};
    b = {1'b0, u};
    p = a * b;
    return p[63:0];
  endfunction

  assign out_valid = out_valid_r;
  assign result    = out_r;
  assign flow_mag  = uabs(prod_r[4]);

  always_comb begin
    state_nxt      = state_r;
    storage_nxt    = storage_r;
    outflow_nxt    = outflow_r;
    prev_nxt       = prev_r;
    ext_nxt        = ext_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    worst_mag_nxt  = worst_mag_r;
    worst_node_nxt = worst_node_r;
    node_nxt       = node_r;
    nodes_nxt      = nodes_r;
    base_nxt       = base_r;
    rm_nxt         = rm_r;
    re_nxt         = re_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_nxt        = out_r;
    hd_pop         = 1'b0;
    div_req.start  = 1'b0;
    div_req.num    = res_r[0];
    div_req.den    = storage_r[0];

    case (state_r)
      // Take the next item from the queue.
      ST_IDLE: begin
        if (head.valid) begin
          hd_pop = 1'b1;
          case (head.item.operation)
            OP_NODE: begin
              prod_nxt[0] = qmul(head.item.fluid_density,    head.item.pore_volume);
              prod_nxt[1] = qmul(head.item.enthalpy_density, head.item.bulk_volume);
              prod_nxt[2] = qmul(head.item.salt_density,     head.item.pore_volume);
              prod_nxt[3] = qmul(head.item.air_density,      head.item.pore_volume);
              prod_nxt[4] = qmul(head.item.mass_term,        head.item.pore_volume);
              prod_nxt[5] = qmul(head.item.energy_term,      head.item.bulk_volume);
              prod_nxt[6] = qmul(head.item.salt_term,        head.item.pore_volume);
              prod_nxt[7] = qmul(head.item.air_term,         head.item.pore_volume);
              node_nxt    = head.item.node_index;
              state_nxt   = ST_ACC;
            end
            OP_SOURCE: begin
              ext_nxt[0] = sadd(ext_r[0], widen(head.item.mass_term));
              ext_nxt[1] = sadd(ext_r[1], widen(head.item.energy_term));
              ext_nxt[2] = sadd(ext_r[2], widen(head.item.salt_term));
              ext_nxt[3] = sadd(ext_r[3], widen(head.item.air_term));
            end
            OP_END: begin
              state_nxt = ST_DIFF;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      // Fold the registered node products into the pass sums.
      ST_ACC: begin
        storage_nxt[0] = sadd(storage_r[0], prod_r[0]);
        storage_nxt[1] = sadd(storage_r[1], prod_r[1]);
        storage_nxt[2] = sadd(storage_r[2], prod_r[2]);
        outflow_nxt[0] = sadd(outflow_r[0], prod_r[4]);
        outflow_nxt[1] = sadd(outflow_r[1], prod_r[5]);
        outflow_nxt[2] = sadd(outflow_r[2], prod_r[6]);
        if (air_enabled) begin
          storage_nxt[3] = sadd(storage_r[3], prod_r[3]);
          outflow_nxt[3] = sadd(outflow_r[3], prod_r[7]);
        end
        if (flow_mag > worst_mag_r) begin
          worst_mag_nxt  = flow_mag;
          worst_node_nxt = node_r;
        end
        if (nodes_r < COUNT_CAP) begin
          nodes_nxt = nodes_r + 21'd1;
        end
        state_nxt = ST_IDLE;
      end
      // Residual chain, one saturating step per cycle.
      ST_DIFF: begin
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = ssub(storage_r[i], prev_r[i]);
        end
        state_nxt = ST_OUTF;
      end
      ST_OUTF: begin
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = sadd(res_r[i], outflow_r[i]);
        end
        state_nxt = ST_EXT;
      end
      ST_EXT: begin
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = ssub(res_r[i], ext_r[i]);
        end
        state_nxt = ST_REL_M;
      end
      // Relative mass residual through the shared divider.
      ST_REL_M: begin
        if (base_r && (storage_r[0] != '0)) begin
          div_req.start = 1'b1;
          state_nxt     = ST_WAIT_M;
        end else begin
          rm_nxt    = '0;
          state_nxt = ST_REL_E;
        end
      end
      ST_WAIT_M: begin
        if (div_rsp.done) begin
          rm_nxt    = div_rsp.quot;
          state_nxt = ST_REL_E;
        end
      end
      // Relative energy residual through the shared divider.
      ST_REL_E: begin
        div_req.num = res_r[1];
        div_req.den = storage_r[1];
        if (base_r && (storage_r[1] != '0)) begin
          div_req.start = 1'b1;
          state_nxt     = ST_WAIT_E;
        end else begin
          re_nxt    = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_WAIT_E: begin
        if (div_rsp.done) begin
          re_nxt    = div_rsp.quot;
          state_nxt = ST_EMIT;
        end
      end
      // Load the output register, then roll storage and clear the pass.
      ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt           = 1'b1;
          out_nxt.mass_residual   = base_r ? res_r[0] : '0;
          out_nxt.energy_residual = base_r ? res_r[1] : '0;
          out_nxt.salt_residual   = base_r ? res_r[2] : '0;
          out_nxt.air_residual    = base_r ? res_r[3] : '0;
          out_nxt.mass_relative   = rm_r;
          out_nxt.energy_relative = re_r;
          out_nxt.mass_storage    = storage_r[0];
          out_nxt.energy_storage  = storage_r[1];
          out_nxt.worst_node      = worst_node_r;
          out_nxt.node_count      = nodes_r;
          out_nxt.baseline_valid  = base_r;
          base_nxt                = 1'b1;
          for (int i = 0; i < 4; i++) begin
            prev_nxt[i]    = storage_r[i];
            storage_nxt[i] = '0;
            outflow_nxt[i] = '0;
            ext_nxt[i]     = '0;
          end
          worst_mag_nxt  = '0;
          worst_node_nxt = '0;
          nodes_nxt      = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      storage_r    <= '{default: '0};
      outflow_r    <= '{default: '0};
      prev_r       <= '{default: '0};
      ext_r        <= '{default: '0};
      worst_mag_r  <= '0;
      worst_node_r <= '0;
      nodes_r      <= '0;
      base_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      storage_r    <= storage_nxt;
      outflow_r    <= outflow_nxt;
      prev_r       <= prev_nxt;
      ext_r        <= ext_nxt;
      worst_mag_r  <= worst_mag_nxt;
      worst_node_r <= worst_node_nxt;
      nodes_r      <= nodes_nxt;
      base_r       <= base_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    node_r <= node_nxt;
    rm_r   <= rm_nxt;
    re_r   <= re_nxt;
    out_r  <= out_nxt;
  end

endmodule

>>> design/mass_energy_balance_checker_core.sv
// ---------------------------------------------------------------------------
// Mass and energy balance checker
// Sums storage and boundary flow per pass and reports conservation residuals.
// ---------------------------------------------------------------------------
//   Channel   Handshake            Payload
//   input     push / full          in_operation .. in_air_term
//   result    empty / pop          out_mass_residual .. out_baseline_valid
//   config    psel/penable/pready  paddr, pwdata, prdata (air_enabled at 0)
//
// A node transfer is multiplied, then accumulated in the back end; a source
// transfer is summed directly; an end-of-pass transfer runs the residual
// chain, then each relative residual, which is zero or is formed by the
// shared bit-serial divider (saturating at once or forming all 30 fraction
// bits), and then the output load.
// Reset is synchronous and clears every sum; there is no clearing pass.
// The front queue holds QDEPTH items; full rises only when it is full, and a
// result waiting on the output stalls the back end only at the next result.
module mass_energy_balance_checker_core import mebc_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             in_operation,
  input  logic [19:0]            in_node_index,
  input  logic [31:0]            in_pore_volume,
  input  logic [31:0]            in_bulk_volume,
  input  logic signed [31:0]     in_fluid_density,
  input  logic signed [31:0]     in_salt_density,
  input  logic signed [31:0]     in_enthalpy_density,
  input  logic signed [31:0]     in_air_density,
  input  logic signed [31:0]     in_mass_term,
  input  logic signed [31:0]     in_energy_term,
  input  logic signed [31:0]     in_salt_term,
  input  logic signed [31:0]     in_air_term,
  // Result channel
  output logic                   empty,
  input  logic                   pop,
  output logic signed [63:0]     out_mass_residual,
  output logic signed [63:0]     out_energy_residual,
  output logic signed [63:0]     out_salt_residual,
  output logic signed [63:0]     out_air_residual,
  output logic signed [31:0]     out_mass_relative,
  output logic signed [31:0]     out_energy_relative,
  output logic signed [63:0]     out_mass_storage,
  output logic signed [63:0]     out_energy_storage,
  output logic [19:0]            out_worst_node,
  output logic [20:0]            out_node_count,
  output logic                   out_baseline_valid,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  item_t    in_item;
  head_t    head;
  logic     hd_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     out_valid;
  result_t  result;
  logic     air_en_r;
  logic     cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == ADDR_AIR_ENABLED) ? {31'd0, air_en_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_en_r <= 1'b0;
    end else if (cfg_wr && (paddr == ADDR_AIR_ENABLED)) begin
      air_en_r <= pwdata[0];
    end
  end

  // Gather the input fields into one item.
  assign in_item.operation        = in_operation;
  assign in_item.node_index       = in_node_index;
  assign in_item.pore_volume      = in_pore_volume;
  assign in_item.bulk_volume      = in_bulk_volume;
  assign in_item.fluid_density    = in_fluid_density;
  assign in_item.salt_density     = in_salt_density;
  assign in_item.enthalpy_density = in_enthalpy_density;
  assign in_item.air_density      = in_air_density;
  assign in_item.mass_term        = in_mass_term;
  assign in_item.energy_term      = in_energy_term;
  assign in_item.salt_term        = in_salt_term;
  assign in_item.air_term         = in_air_term;

  mebc_front #(
    .DEPTH (QDEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .item   (in_item),
    .full   (full),
    .head   (head),
    .hd_pop (hd_pop)
  );

  mebc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .air_enabled (air_en_r),
    .head        (head),
    .hd_pop      (hd_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .result      (result),
    .out_pop     (pop)
  );

  mebc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Result channel.
  assign empty               = !out_valid;
  assign out_mass_residual   = result.mass_residual;
  assign out_energy_residual = result.energy_residual;
  assign out_salt_residual   = result.salt_residual;
  assign out_air_residual    = result.air_residual;
  assign out_mass_relative   = result.mass_relative;
  assign out_energy_relative = result.energy_relative;
  assign out_mass_storage    = result.mass_storage;
  assign out_energy_storage  = result.energy_storage;
  assign out_worst_node      = result.worst_node;
  assign out_node_count      = result.node_count;
  assign out_baseline_valid  = result.baseline_valid;

endmodule

>>> design/mebc_checker.sv
// ---------------------------------------------------------------------------
// Balance checker port assertions
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
`include "mass_energy_balance_checker_core_macros.svh"

module mebc_checker import mebc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic signed [63:0]    out_mass_residual,
  input logic signed [63:0]    out_energy_residual,
  input logic signed [63:0]    out_salt_residual,
  input logic signed [63:0]    out_air_residual,
  input logic signed [31:0]    out_mass_relative,
  input logic signed [31:0]    out_energy_relative,
  input logic [19:0]           out_worst_node,
  input logic [20:0]           out_node_count,
  input logic                  out_baseline_valid
);

  // Reset leaves both queues empty.
  `MEBC_ASSERT_RST(a_reset_empty, clk, rst_n, empty && !full, "queues not empty after reset")

  // The first pass after reset reports no residuals.
  `MEBC_ASSERT_IMP(a_first_pass_zero, clk, rst_n, !empty && !out_baseline_valid,
    (out_mass_residual == 0) && (out_energy_residual == 0) && (out_salt_residual == 0) &&
    (out_air_residual == 0) && (out_mass_relative == 0) && (out_energy_relative == 0),
    "residual reported on first pass")

  // An empty pass names no worst node, and the count stays within its cap.
  `MEBC_ASSERT_IMP(a_count_worst, clk, rst_n, !empty,
    (out_node_count <= COUNT_CAP) && ((out_node_count != 0) || (out_worst_node == 0)),
    "node count or worst node inconsistent")

  // A result that is not taken stays on the ports.
  `MEBC_ASSERT_NXT(a_result_hold, clk, rst_n, !empty && !pop,
    !empty && $stable(out_mass_residual) && $stable(out_node_count),
    "result changed while stalled")

endmodule

bind mass_energy_balance_checker_core mebc_checker u_mebc_checker (.*);

>>> tb/sv/mass_energy_balance_checker_core_tb.sv
// ---------------------------------------------------------------------------
// Testbench for the mass and energy balance checker
// Streams node, source and end-of-pass items through the input queue, keeps
// its own copy of the per-pass sums and checks every pass result against it.
// Both sides of the block idle at random, and the air setting changes
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module mass_energy_balance_checker_core_tb import mebc_pkg::*; ;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Random part length, idle cycles before a register write and the run limit.
  localparam int RANDOM_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 120;
  localparam int TIMEOUT_UNITS = 2_000_000;

  // Expected pass results, built from a private copy of the balance sums.
  class balance_tracker;
    localparam int MASS   = 0;
    localparam int ENERGY = 1;
    localparam int SALT   = 2;
    localparam int AIR    = 3;

    logic signed [63:0] storage [4];
    logic signed [63:0] outflow [4];
    logic signed [63:0] prev_storage [4];
    logic signed [63:0] external [4];
    logic [63:0]        worst_mag;
    logic [19:0]        worst_idx;
    logic [20:0]        count;
    bit                 baseline;
    bit                 air_on;
    result_t            pending_passes[$];
    int                 errors;
    int                 results_checked;
    int                 op_count [4];

    function new();
      clear_pass();
      foreach (prev_storage[k]) prev_storage[k] = '0;
      baseline = 0;
      air_on   = 0;
      errors   = 0;
      results_checked = 0;
      foreach (op_count[k]) op_count[k] = 0;
    endfunction

    function void clear_pass();
      foreach (storage[k]) begin
        storage[k]  = '0;
        outflow[k]  = '0;
        external[k] = '0;
      end
      worst_mag = '0;
      worst_idx = '0;
      count     = '0;
    endfunction

    function int pending();
      return pending_passes.size();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("ERROR at %0t: %s", $realtime, msg);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        note_error($sformatf("%s expected %h, got %h", name, want, got));
      end
    endfunction

    // Signed 64-bit add or subtract, clamped to the signed range.
    function logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b,
                                         bit subtract);
      logic [64:0] w;
      w = subtract ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
      case (w[64:63])
        2'b01:   return SMAX;
        2'b10:   return SMIN;
        default: return w[63:0];
      endcase
    endfunction

    // Exact Q32.32 product of a signed Q16.16 value and an unsigned volume.
    function logic signed [63:0] scaled(logic signed [31:0] density, logic [31:0] vol);
      longint a;
      longint b;
      a = density;
      b = {32'd0, vol};
      return a * b;
    endfunction

    function logic [63:0] magnitude(logic signed [63:0] x);
      logic [63:0] u;
      u = x;
      return x[63] ? (~u + 64'd1) : u;
    endfunction

    // Residual over |storage| in Q1.30, truncated toward zero and clamped.
    function logic signed [31:0] ratio_q30(logic signed [63:0] res, logic signed [63:0] den);
      logic [63:0]  n;
      logic [63:0]  d;
      logic [127:0] q;
      n = magnitude(res);
      d = magnitude(den);
      q = {34'd0, n, 30'd0} / {64'd0, d};
      if (res[63]) begin
        return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
      end
      return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    // Update the sums for one accepted input transfer.
    function void absorb_item(item_t it);
      logic signed [63:0] flow;
      logic signed [63:0] acc;
      logic signed [63:0] res [4];
      logic [63:0]        mag;
      result_t            r;
      op_count[it.operation]++;
      case (it.operation)
        OP_NODE: begin
          storage[MASS]   = sat_sum(storage[MASS], scaled(it.fluid_density, it.pore_volume), 0);
          storage[SALT]   = sat_sum(storage[SALT], scaled(it.salt_density, it.pore_volume), 0);
          storage[ENERGY] = sat_sum(storage[ENERGY],
                                    scaled(it.enthalpy_density, it.bulk_volume), 0);
          if (air_on) begin
            storage[AIR] = sat_sum(storage[AIR], scaled(it.air_density, it.pore_volume), 0);
          end
          flow = scaled(it.mass_term, it.pore_volume);
          mag  = magnitude(flow);
          outflow[MASS]   = sat_sum(outflow[MASS], flow, 0);
          outflow[ENERGY] = sat_sum(outflow[ENERGY], scaled(it.energy_term, it.bulk_volume), 0);
          outflow[SALT]   = sat_sum(outflow[SALT], scaled(it.salt_term, it.pore_volume), 0);
          if (air_on) begin
            outflow[AIR] = sat_sum(outflow[AIR], scaled(it.air_term, it.pore_volume), 0);
          end
          // Only a strictly larger flow takes over the worst node.
          if (mag > worst_mag) begin
            worst_mag = mag;
            worst_idx = it.node_index;
          end
          if (count < COUNT_CAP) begin
            count++;
          end
        end
        OP_SOURCE: begin
          external[MASS]   = sat_sum(external[MASS],
                                     {{16{it.mass_term[31]}}, it.mass_term, 16'h0}, 0);
          external[ENERGY] = sat_sum(external[ENERGY],
                                     {{16{it.energy_term[31]}}, it.energy_term, 16'h0}, 0);
          external[SALT]   = sat_sum(external[SALT],
                                     {{16{it.salt_term[31]}}, it.salt_term, 16'h0}, 0);
          external[AIR]    = sat_sum(external[AIR],
                                     {{16{it.air_term[31]}}, it.air_term, 16'h0}, 0);
        end
        OP_END: begin
          r = '0;
          // Residuals stay zero on the first pass, which only sets the baseline.
          if (baseline) begin
            foreach (res[k]) begin
              acc    = sat_sum(storage[k], prev_storage[k], 1);
              acc    = sat_sum(acc, outflow[k], 0);
              res[k] = sat_sum(acc, external[k], 1);
            end
            r.mass_residual   = res[MASS];
            r.energy_residual = res[ENERGY];
            r.salt_residual   = res[SALT];
            r.air_residual    = res[AIR];
            if (storage[MASS] != 0) begin
              r.mass_relative = ratio_q30(res[MASS], storage[MASS]);
            end
            if (storage[ENERGY] != 0) begin
              r.energy_relative = ratio_q30(res[ENERGY], storage[ENERGY]);
            end
          end
          r.mass_storage   = storage[MASS];
          r.energy_storage = storage[ENERGY];
          r.worst_node     = worst_idx;
          r.node_count     = count;
          r.baseline_valid = baseline;
          pending_passes.push_back(r);
          baseline     = 1;
          prev_storage = storage;
          clear_pass();
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one popped result with the oldest expected pass result.
    function void check_pass_result(result_t got);
      result_t want;
      if (pending_passes.size() == 0) begin
        note_error("result transfer with no pass result expected");
        return;
      end
      want = pending_passes.pop_front();
      results_checked++;
      compare_field("mass_residual", want.mass_residual, got.mass_residual);
      compare_field("energy_residual", want.energy_residual, got.energy_residual);
      compare_field("salt_residual", want.salt_residual, got.salt_residual);
      compare_field("air_residual", want.air_residual, got.air_residual);
      compare_field("mass_relative", want.mass_relative, got.mass_relative);
      compare_field("energy_relative", want.energy_relative, got.energy_relative);
      compare_field("mass_storage", want.mass_storage, got.mass_storage);
      compare_field("energy_storage", want.energy_storage, got.energy_storage);
      compare_field("worst_node", want.worst_node, got.worst_node);
      compare_field("node_count", want.node_count, got.node_count);
      compare_field("baseline_valid", want.baseline_valid, got.baseline_valid);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [1:0]            in_operation;
  logic [19:0]           in_node_index;
  logic [31:0]           in_pore_volume;
  logic [31:0]           in_bulk_volume;
  logic signed [31:0]    in_fluid_density;
  logic signed [31:0]    in_salt_density;
  logic signed [31:0]    in_enthalpy_density;
  logic signed [31:0]    in_air_density;
  logic signed [31:0]    in_mass_term;
  logic signed [31:0]    in_energy_term;
  logic signed [31:0]    in_salt_term;
  logic signed [31:0]    in_air_term;
  logic                  empty;
  logic                  pop;
  logic signed [63:0]    out_mass_residual;
  logic signed [63:0]    out_energy_residual;
  logic signed [63:0]    out_salt_residual;
  logic signed [63:0]    out_air_residual;
  logic signed [31:0]    out_mass_relative;
  logic signed [31:0]    out_energy_relative;
  logic signed [63:0]    out_mass_storage;
  logic signed [63:0]    out_energy_storage;
  logic [19:0]           out_worst_node;
  logic [20:0]           out_node_count;
  logic                  out_baseline_valid;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  balance_tracker sb = new();

  int burst_left;
  int rx_cycle;
  int rx_mode;
  int cfg_writes;
  int air_phases;
  int phase_count;

  mass_energy_balance_checker_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_operation        (in_operation),
    .in_node_index       (in_node_index),
    .in_pore_volume      (in_pore_volume),
    .in_bulk_volume      (in_bulk_volume),
    .in_fluid_density    (in_fluid_density),
    .in_salt_density     (in_salt_density),
    .in_enthalpy_density (in_enthalpy_density),
    .in_air_density      (in_air_density),
    .in_mass_term        (in_mass_term),
    .in_energy_term      (in_energy_term),
    .in_salt_term        (in_salt_term),
    .in_air_term         (in_air_term),
    .empty               (empty),
    .pop                 (pop),
    .out_mass_residual   (out_mass_residual),
    .out_energy_residual (out_energy_residual),
    .out_salt_residual   (out_salt_residual),
    .out_air_residual    (out_air_residual),
    .out_mass_relative   (out_mass_relative),
    .out_energy_relative (out_energy_relative),
    .out_mass_storage    (out_mass_storage),
    .out_energy_storage  (out_energy_storage),
    .out_worst_node      (out_worst_node),
    .out_node_count      (out_node_count),
    .out_baseline_valid  (out_baseline_valid),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit, in case a handshake never completes.
  initial begin
    #(TIMEOUT_UNITS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic item_t compose(input logic [1:0] op, input logic [19:0] idx,
                                    input logic [31:0] pv, bv, fl, sa, en, ai,
                                    input logic [31:0] mt, et, st, at);
    item_t it;
    it.operation        = op;
    it.node_index       = idx;
    it.pore_volume      = pv;
    it.bulk_volume      = bv;
    it.fluid_density    = fl;
    it.salt_density     = sa;
    it.enthalpy_density = en;
    it.air_density      = ai;
    it.mass_term        = mt;
    it.energy_term      = et;
    it.salt_term        = st;
    it.air_term         = at;
    return it;
  endfunction

  // Mostly small signed values, with some extremes and some full-range words.
  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    case ($urandom_range(0, 15))
      0:       v = 32'h0000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'h8000_0000;
      3:       v = 32'hFFFF_FFFF;
      4, 5, 6: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0008_0000);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic item_t random_item(input logic [1:0] op);
    return compose(op, 20'($urandom), pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word());
  endfunction

  // Input transfer; the sender works in bursts separated by random gaps.
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    push                = 1'b1;
    in_operation        = it.operation;
    in_node_index       = it.node_index;
    in_pore_volume      = it.pore_volume;
    in_bulk_volume      = it.bulk_volume;
    in_fluid_density    = it.fluid_density;
    in_salt_density     = it.salt_density;
    in_enthalpy_density = it.enthalpy_density;
    in_air_density      = it.air_density;
    in_mass_term        = it.mass_term;
    in_energy_term      = it.energy_term;
    in_salt_term        = it.salt_term;
    in_air_term         = it.air_term;
    do @(posedge clk); while (full);
    sb.absorb_item(it);
    burst_left--;
  endtask

  // Stop sending and wait until every pass result has been popped.
  task automatic wait_results(input bit settle);
    @(negedge clk);
    push       = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input bit write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write the air setting with random upper bits, then read it back.
  task automatic set_air(input bit on);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = {31'($urandom), on};
    cfg_access(1'b1, ADDR_AIR_ENABLED, wdata, rdata);
    sb.air_on = on;
    cfg_writes++;
    cfg_access(1'b0, ADDR_AIR_ENABLED, 32'h0, rdata);
    sb.compare_field("air_enabled readback", {63'd0, on}, rdata);
  endtask

  // Result receiver: the pop pattern is redrawn at random from four modes.
  initial begin
    pop      = 1'b0;
    rx_cycle = 0;
    rx_mode  = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 80 == 0) begin
        rx_mode = $urandom_range(0, 3);
      end
      case (rx_mode)
        0:       pop = 1'b1;
        1:       pop = $urandom_range(0, 1);
        2:       pop = (rx_cycle % 5 == 0);
        default: pop = ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Check each result transfer at the rising edge that accepts it.
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && pop && !empty) begin
      got.mass_residual   = out_mass_residual;
      got.energy_residual = out_energy_residual;
      got.salt_residual   = out_salt_residual;
      got.air_residual    = out_air_residual;
      got.mass_relative   = out_mass_relative;
      got.energy_relative = out_energy_relative;
      got.mass_storage    = out_mass_storage;
      got.energy_storage  = out_energy_storage;
      got.worst_node      = out_worst_node;
      got.node_count      = out_node_count;
      got.baseline_valid  = out_baseline_valid;
      sb.check_pass_result(got);
    end
  end

  // Main sequence: reset, directed passes, then random phases.
  initial begin
    int          sent;
    int          passes;
    int          len;
    int          pick;
    bit          air;
    logic [1:0]  op;
    item_t       blank;

    rst_n               = 1'b0;
    push                = 1'b0;
    in_operation        = OP_NODE;
    in_node_index       = '0;
    in_pore_volume      = '0;
    in_bulk_volume      = '0;
    in_fluid_density    = '0;
    in_salt_density     = '0;
    in_enthalpy_density = '0;
    in_air_density      = '0;
    in_mass_term        = '0;
    in_energy_term      = '0;
    in_salt_term        = '0;
    in_air_term         = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    burst_left          = 0;
    cfg_writes          = 0;
    air_phases          = 0;
    phase_count         = 0;
    sent                = 0;
    blank = compose(OP_END, 20'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // First pass after reset only sets the baseline.
    send_item(blank);
    // External deltas alone: nonzero residual over zero storage.
    send_item(compose(OP_SOURCE, 20'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001));
    send_item(blank);
    // Extreme nodes; the second one ties the worst flow and must not replace it.
    send_item(compose(OP_NODE, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(compose(OP_NODE, 20'h00000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    // Zero volumes give zero products.
    send_item(compose(OP_NODE, 20'h5A5A5, 32'h0, 32'h0,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    // The unused code changes nothing.
    send_item(compose(OP_UNUSED, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(blank);

    wait_results(1'b1);
    set_air(1'b1);
    // Small values with air summed; the second node has the larger flow.
    send_item(compose(OP_NODE, 20'h00011, 32'h0001_0000, 32'h0002_0000,
                      32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000, 32'h0000_2000,
                      32'h0000_1000, 32'hFFFF_F000, 32'h0000_0800, 32'h0000_0400));
    send_item(compose(OP_NODE, 20'h00022, 32'h0003_0000, 32'h0001_0000,
                      32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0000_4000,
                      32'hFFFF_E000, 32'h0000_1000, 32'h0000_0000, 32'hFFFF_FC00));
    send_item(compose(OP_SOURCE, 20'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h0000_8000, 32'hFFFF_8000, 32'h0000_0100, 32'h0000_0200));
    send_item(blank);
    // Large negative nodes drive the storage sums to the negative limit.
    repeat (3) begin
      send_item(compose(OP_NODE, 20'h80000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    end
    send_item(blank);
    // Empty pass after a saturated one: the difference saturates too.
    send_item(blank);

    wait_results(1'b1);
    set_air(1'b0);
    // Air disabled: air storage and outflow drop out, air deltas still count.
    send_item(compose(OP_NODE, 20'h0F0F0, 32'h0002_0000, 32'h0002_0000,
                      32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF,
                      32'h0000_1000, 32'h0000_1000, 32'h0000_1000, 32'h7FFF_FFFF));
    send_item(compose(OP_SOURCE, 20'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h0, 32'h0, 32'h0, 32'h8000_0000));
    send_item(blank);

    // Random phases of well-formed passes with a little noise mixed in.
    while (sent < RANDOM_ITEMS) begin
      wait_results(1'b1);
      air = (phase_count < 2) ? phase_count[0] : 1'($urandom_range(0, 1));
      set_air(air);
      phase_count++;
      if (air) begin
        air_phases++;
      end
      passes = $urandom_range(2, 6);
      repeat (passes) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          op   = (pick < 80) ? OP_NODE : ((pick < 96) ? OP_SOURCE : OP_UNUSED);
          send_item(random_item(op));
          if (op != OP_UNUSED) begin
            sent++;
          end
        end
        send_item(random_item(OP_END));
        sent++;
        // Now and then hold the sender until the block has drained.
        if ($urandom_range(0, 4) == 0) begin
          wait_results(1'b0);
        end
      end
    end

    wait_results(1'b1);
    $display("Covered %0d node, %0d source and %0d ignored transfers, %0d pass results.",
             sb.op_count[OP_NODE], sb.op_count[OP_SOURCE], sb.op_count[OP_UNUSED],
             sb.results_checked);
    $display("Made %0d register writes over %0d random phases, %0d with air summed.",
             cfg_writes, phase_count, air_phases);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
